// File: rtl/lrupr_pkg.sv
package lrupr_pkg;

  // Frame store geometry
  localparam int MAX_FRAMES = 8;
  localparam int FRAME_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CFG_W      = 4;
  // Frame counts hold 0..MAX_FRAMES and must also cover the configured count
  localparam int COUNT_W    = ($clog2(MAX_FRAMES + 1) > CFG_W) ? $clog2(MAX_FRAMES + 1) : CFG_W;

  // Field widths
  localparam int PAGE_W  = 8;
  localparam int STAMP_W = 32;
  localparam int FAULT_W = 16;

  localparam logic [CFG_W-1:0]   NUM_FRAMES_RESET = CFG_W'(8);
  localparam logic [FAULT_W-1:0] FAULT_MAX        = '1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lrupr_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture a new reference, restart the scan
    logic step;    // examine one frame
    logic commit;  // apply the update and load the result register
  } lrupr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;  // frame being examined is the last one
    logic out_full;   // result register holds a result that is stalled
  } lrupr_sts_t;

endpackage

// File: rtl/lru_page_replacement.sv
// LRU page replacement. Each page reference takes one transfer on the input
// channel and gives exactly one result transfer. After a reference is accepted,
// the scan walks all MAX_FRAMES (8) frames one frame per cycle looking for a match
// and the oldest stamp; the update state then applies the update and loads the
// result register, and the controller returns to idle to take the next reference.
// The next reference is taken once the update is done, even while the result
// is still stalled; the update itself waits while an older result is held.
// num_frames may be written (cfg_valid, cfg_ready always high) only while idle.
module lru_page_replacement (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lrupr_pkg::PAGE_W-1:0]        page_id,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                is_fault,
  output logic [2:0]                          frame_slot,
  output logic                                evicted_valid,
  output logic [lrupr_pkg::PAGE_W-1:0]        evicted_page,
  output logic [lrupr_pkg::FAULT_W-1:0]       fault_total,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lrupr_pkg::CFG_W-1:0]         cfg_data
);

  lrupr_pkg::lrupr_cmd_t cmd;
  lrupr_pkg::lrupr_sts_t sts;

  assign cfg_ready = 1'b1;

  lrupr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lrupr_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .page_id       (page_id),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_fault      (is_fault),
    .frame_slot    (frame_slot),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
  );

endmodule

// File: rtl/lrupr_ctrl.sv
module lrupr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lrupr_pkg::lrupr_sts_t sts,
  output lrupr_pkg::lrupr_cmd_t cmd
);

  lrupr_pkg::lrupr_state_t state;
  lrupr_pkg::lrupr_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrupr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lrupr_pkg::ST_IDLE: begin
        if (in_valid) state_next = lrupr_pkg::ST_SCAN;
      end
      lrupr_pkg::ST_SCAN: begin
        if (sts.scan_last) state_next = lrupr_pkg::ST_UPDATE;
      end
      lrupr_pkg::ST_UPDATE: begin
        if (!sts.out_full) state_next = lrupr_pkg::ST_IDLE;
      end
      default: state_next = lrupr_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      lrupr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      lrupr_pkg::ST_SCAN: begin
        cmd.step = 1'b1;
      end
      lrupr_pkg::ST_UPDATE: begin
        cmd.commit = !sts.out_full;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/lrupr_datapath.sv
module lrupr_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  lrupr_pkg::lrupr_cmd_t               cmd,
  output lrupr_pkg::lrupr_sts_t               sts,
  input  logic [lrupr_pkg::PAGE_W-1:0]        page_id,
  input  logic                                cfg_valid,
  input  logic [lrupr_pkg::CFG_W-1:0]         cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                is_fault,
  output logic [2:0]                          frame_slot,
  output logic                                evicted_valid,
  output logic [lrupr_pkg::PAGE_W-1:0]        evicted_page,
  output logic [lrupr_pkg::FAULT_W-1:0]       fault_total
);

  // Frame stores, no reset: only filled frames are consulted
  logic [lrupr_pkg::PAGE_W-1:0]  resident_page  [lrupr_pkg::MAX_FRAMES];
  logic [lrupr_pkg::STAMP_W-1:0] last_use_stamp [lrupr_pkg::MAX_FRAMES];

  // Control state
  logic [lrupr_pkg::CFG_W-1:0]   num_frames;
  logic [lrupr_pkg::COUNT_W-1:0] frames_filled;
  logic [lrupr_pkg::STAMP_W-1:0] use_clock;
  logic [lrupr_pkg::FAULT_W-1:0] fault_counter;

  // Per-reference scan state
  logic [lrupr_pkg::PAGE_W-1:0]  ref_page;
  logic [lrupr_pkg::FRAME_W-1:0] scan_idx;
  logic                          hit_found;
  logic [lrupr_pkg::FRAME_W-1:0] hit_slot;
  logic [lrupr_pkg::STAMP_W-1:0] best_stamp;
  logic [lrupr_pkg::FRAME_W-1:0] best_slot;
  logic [lrupr_pkg::PAGE_W-1:0]  best_page;

  logic [lrupr_pkg::COUNT_W-1:0] active_frames;
  logic [lrupr_pkg::COUNT_W-1:0] scan_ext;
  logic [lrupr_pkg::PAGE_W-1:0]  cur_page;
  logic [lrupr_pkg::STAMP_W-1:0] cur_stamp;
  logic                          fill_free;
  logic [lrupr_pkg::FRAME_W-1:0] slot_sel;
  logic [lrupr_pkg::STAMP_W-1:0] use_clock_next;
  logic [lrupr_pkg::FAULT_W-1:0] fault_counter_next;

  // Clamp the configured frame count to 1..MAX_FRAMES
  always_comb begin
    if (num_frames == '0) begin
      active_frames = lrupr_pkg::COUNT_W'(1);
    end else if (lrupr_pkg::COUNT_W'(num_frames) > lrupr_pkg::COUNT_W'(lrupr_pkg::MAX_FRAMES)) begin
      active_frames = lrupr_pkg::COUNT_W'(lrupr_pkg::MAX_FRAMES);
    end else begin
      active_frames = lrupr_pkg::COUNT_W'(num_frames);
    end
  end

  // Frame under examination
  assign scan_ext  = lrupr_pkg::COUNT_W'(scan_idx);
  assign cur_page  = resident_page[scan_idx];
  assign cur_stamp = last_use_stamp[scan_idx];

  assign sts.scan_last = (scan_idx == lrupr_pkg::FRAME_W'(lrupr_pkg::MAX_FRAMES - 1));
  assign sts.out_full  = out_valid && out_stall;

  // Update decision
  assign fill_free      = frames_filled < active_frames;
  assign use_clock_next = use_clock + 1'b1;
  assign fault_counter_next = (fault_counter == lrupr_pkg::FAULT_MAX) ?
                              fault_counter : fault_counter + 1'b1;

  always_comb begin
    if (hit_found) begin
      slot_sel = hit_slot;
    end else if (fill_free) begin
      slot_sel = frames_filled[lrupr_pkg::FRAME_W-1:0];
    end else begin
      slot_sel = best_slot;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_frames <= lrupr_pkg::NUM_FRAMES_RESET;
    end else if (cfg_valid) begin
      num_frames <= cfg_data;
    end
  end

  // Scan: first matching filled frame, and oldest stamp among active frames
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ref_page  <= page_id;
      scan_idx  <= '0;
      hit_found <= 1'b0;
    end else if (cmd.step) begin
      scan_idx <= scan_idx + 1'b1;
      if (!hit_found && scan_ext < frames_filled && cur_page == ref_page) begin
        hit_found <= 1'b1;
        hit_slot  <= scan_idx;
      end
      if (scan_ext < active_frames && (scan_idx == '0 || cur_stamp < best_stamp)) begin
        best_stamp <= cur_stamp;
        best_slot  <= scan_idx;
        best_page  <= cur_page;
      end
    end
  end

  // Frame store writes
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      last_use_stamp[slot_sel] <= use_clock_next;
      if (!hit_found) resident_page[slot_sel] <= ref_page;
    end
  end

  // Counters
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_filled <= '0;
      use_clock     <= '0;
      fault_counter <= '0;
    end else if (cmd.commit) begin
      use_clock <= use_clock_next;
      if (!hit_found) fault_counter <= fault_counter_next;
      if (!hit_found && fill_free) frames_filled <= frames_filled + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      is_fault      <= !hit_found;
      frame_slot    <= 3'(slot_sel);
      evicted_valid <= !hit_found && !fill_free;
      evicted_page  <= (!hit_found && !fill_free) ? best_page : '0;
      fault_total   <= hit_found ? fault_counter : fault_counter_next;
    end
  end

endmodule

// File: rtl/lrupr_checker.sv
module lrupr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          is_fault,
  input logic                          evicted_valid,
  input logic [lrupr_pkg::PAGE_W-1:0]  evicted_page
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // After an input transfer the block is busy scanning
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transfer");

  // Eviction only on a fault
  a_evict_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted_valid |-> is_fault)
    else $error("eviction reported on a hit");

  // Evicted page is zero when nothing was evicted
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted_valid |-> evicted_page == '0)
    else $error("evicted page nonzero without eviction");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .is_fault      (is_fault),
  .evicted_valid (evicted_valid),
  .evicted_page  (evicted_page)
);
